FILE: rtl/core/tcag_pkg.sv
`timescale 1ns / 1ps

package tcag_pkg;

   // Default sizes handed to the top level.
   localparam int DEF_MAX_DIMS    = 4;
   localparam int DEF_MAX_SOURCES = 4;
   localparam int DEF_ADDR_BITS   = 32;

   // Widths fixed by the request and response fields.
   localparam int WORD_W   = 32;
   localparam int SEL_W    = 3;
   localparam int SLOT_W   = 4;
   localparam int NUM_W    = 2;
   localparam int CSR_IDX_W = 3;

   // Quotient bits resolved by each divider stage.
   localparam int DIV_STEP_BITS = 4;
   localparam int DIV_STEPS     = WORD_W / DIV_STEP_BITS;

   typedef enum logic {
      OP_ELEMENT = 1'b0,
      OP_TABLE   = 1'b1
   } op_type;

   typedef enum logic [SEL_W-1:0] {
      TBL_SHAPE       = 3'd0,
      TBL_AXIS_SIZE   = 3'd1,
      TBL_STRIDE      = 3'd2,
      TBL_VIEW_OFFSET = 3'd3,
      TBL_BUF_OFFSET  = 3'd4
   } tbl_sel_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIMS    = 3'd0,
      CSR_JOIN    = 3'd1,
      CSR_SOURCES = 3'd2,
      CSR_COUNT   = 3'd3
   } csr_idx_type;

   // Control that travels with every pipeline stage.
   typedef struct packed {
      logic valid;
      logic oor;
   } ctl_type;

endpackage

FILE: rtl/core/tcag_if.sv
`timescale 1ns / 1ps

// Request channel: element requests and table writes.
interface tcag_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] element_index;
   logic [2:0]  table_select;
   logic [3:0]  table_slot;
   logic [31:0] table_word;

   modport source (output valid, op, element_index, table_select, table_slot, table_word,
                   input ready);
   modport sink   (input valid, op, element_index, table_select, table_slot, table_word,
                   output ready);
endinterface

// Response channel: one gather address per element request.
interface tcag_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] source_address;
   logic [1:0]  source_number;
   logic        out_of_range;

   modport source (output valid, source_address, source_number, out_of_range,
                   input ready);
   modport sink   (input valid, source_address, source_number, out_of_range,
                   output ready);
endinterface

// Register write channel.
interface tcag_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/tcag_tables.sv
`timescale 1ns / 1ps

module tcag_tables
   import tcag_pkg::*;
#(
   parameter int MAX_DIMS    = DEF_MAX_DIMS,
   parameter int MAX_SOURCES = DEF_MAX_SOURCES,
   localparam int RUN_W      = WORD_W + $clog2(MAX_SOURCES + 1)
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [SEL_W-1:0]                              wr_sel,
   input  logic [SLOT_W-1:0]                             wr_slot,
   input  logic [WORD_W-1:0]                             wr_word,
   output logic [MAX_DIMS-1:0][WORD_W-1:0]               shape,
   output logic [MAX_SOURCES-1:0][MAX_DIMS-1:0][WORD_W-1:0] stride,
   output logic [MAX_SOURCES-1:0][WORD_W-1:0]            view_offset,
   output logic [MAX_SOURCES-1:0][WORD_W-1:0]            buf_offset,
   output logic [MAX_SOURCES-1:0][RUN_W-1:0]             range_lo,
   output logic [MAX_SOURCES-1:0][RUN_W-1:0]             range_hi
);

   logic [MAX_DIMS-1:0][WORD_W-1:0]                 shape_ff;
   logic [MAX_SOURCES-1:0][WORD_W-1:0]              size_ff;
   logic [MAX_SOURCES-1:0][MAX_DIMS-1:0][WORD_W-1:0] stride_ff;
   logic [MAX_SOURCES-1:0][WORD_W-1:0]              view_ff;
   logic [MAX_SOURCES-1:0][WORD_W-1:0]              buf_ff;
   logic [MAX_SOURCES-1:0][RUN_W-1:0]               lo_ff, lo_in;
   logic [MAX_SOURCES-1:0][RUN_W-1:0]               hi_ff, hi_in;

   // Table writes; a slot past the table depth matches no entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         unique case (wr_sel)
            TBL_SHAPE: begin
               for (int d = 0; d < MAX_DIMS; d++)
                  if (int'(wr_slot) == d) shape_ff[d] <= wr_word;
            end
            TBL_AXIS_SIZE: begin
               for (int s = 0; s < MAX_SOURCES; s++)
                  if (int'(wr_slot) == s) size_ff[s] <= wr_word;
            end
            TBL_STRIDE: begin
               for (int s = 0; s < MAX_SOURCES; s++)
                  for (int d = 0; d < MAX_DIMS; d++)
                     if (int'(wr_slot) == s * MAX_DIMS + d) stride_ff[s][d] <= wr_word;
            end
            TBL_VIEW_OFFSET: begin
               for (int s = 0; s < MAX_SOURCES; s++)
                  if (int'(wr_slot) == s) view_ff[s] <= wr_word;
            end
            TBL_BUF_OFFSET: begin
               for (int s = 0; s < MAX_SOURCES; s++)
                  if (int'(wr_slot) == s) buf_ff[s] <= wr_word;
            end
            default: ;
         endcase
      end
   end

   // Running ranges along the join axis, kept exactly without wrap.
   always_comb begin
      logic [RUN_W-1:0] run;
      run = '0;
      for (int s = 0; s < MAX_SOURCES; s++) begin
         lo_in[s] = run;
         run      = run + RUN_W'(size_ff[s]);
         hi_in[s] = run;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   assign shape       = shape_ff;
   assign stride      = stride_ff;
   assign view_offset = view_ff;
   assign buf_offset  = buf_ff;
   assign range_lo    = lo_ff;
   assign range_hi    = hi_ff;

endmodule

FILE: rtl/core/tcag_divider.sv
`timescale 1ns / 1ps

module tcag_divider
   import tcag_pkg::*;
#(
   parameter int MAX_DIMS = DEF_MAX_DIMS,
   localparam int CNT_D   = $clog2(MAX_DIMS + 1),
   localparam int NST     = MAX_DIMS * DIV_STEPS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            enable,
   input  logic [MAX_DIMS-1:0][WORD_W-1:0] shape,
   input  logic [CNT_D-1:0]                dims_eff,
   input  ctl_type                         in_ctl,
   input  logic [WORD_W-1:0]               in_index,
   output ctl_type                         out_ctl,
   output logic [MAX_DIMS-1:0][WORD_W-1:0] out_coord
);

   ctl_type                         ctl_ff   [NST];
   logic [WORD_W-1:0]               quo_ff   [NST];
   logic [WORD_W:0]                 part_ff  [NST];
   logic [MAX_DIMS-1:0][WORD_W-1:0] coord_ff [NST];

   genvar i;
   generate
      for (i = 0; i < NST; i++) begin : g_stage
         localparam int LEVEL = i / DIV_STEPS;
         localparam int STEP  = i % DIV_STEPS;

         ctl_type                         prv_ctl;
         logic [WORD_W-1:0]               prv_quo;
         logic [WORD_W:0]                 prv_part;
         logic [MAX_DIMS-1:0][WORD_W-1:0] prv_coord;
         logic [WORD_W-1:0]               quo_in;
         logic [WORD_W:0]                 part_in;
         logic [MAX_DIMS-1:0][WORD_W-1:0] coord_in;

         if (i == 0) begin : g_first
            assign prv_ctl   = in_ctl;
            assign prv_quo   = in_index;
            assign prv_part  = '0;
            assign prv_coord = '0;
         end else begin : g_next
            assign prv_ctl   = ctl_ff[i-1];
            assign prv_quo   = quo_ff[i-1];
            assign prv_part  = (STEP == 0) ? '0 : part_ff[i-1];
            assign prv_coord = coord_ff[i-1];
         end

         // Restoring division, innermost dimension first; each level divides
         // the running quotient by one shape entry.
         always_comb begin
            logic [WORD_W-1:0] divisor;
            logic              active;
            logic [WORD_W-1:0] q;
            logic [WORD_W:0]   p;
            active  = int'(dims_eff) > LEVEL;
            divisor = '0;
            for (int d = 0; d < MAX_DIMS; d++)
               if (active && d == int'(dims_eff) - 1 - LEVEL) divisor = shape[d];
            q = prv_quo;
            p = prv_part;
            for (int b = 0; b < DIV_STEP_BITS; b++) begin
               p = {p[WORD_W-1:0], q[WORD_W-1]};
               q = {q[WORD_W-2:0], 1'b0};
               if (p >= {1'b0, divisor}) begin
                  p    = p - {1'b0, divisor};
                  q[0] = 1'b1;
               end
            end
            coord_in = prv_coord;
            if (STEP == DIV_STEPS - 1) begin
               for (int d = 0; d < MAX_DIMS; d++)
                  if (active && d == int'(dims_eff) - 1 - LEVEL) coord_in[d] = p[WORD_W-1:0];
            end
            quo_in  = q;
            part_in = p;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               ctl_ff[i].valid <= 1'b0;
            end else if (enable) begin
               ctl_ff[i].valid <= prv_ctl.valid;
            end
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               ctl_ff[i].oor <= prv_ctl.oor;
               quo_ff[i]     <= quo_in;
               part_ff[i]    <= part_in;
               coord_ff[i]   <= coord_in;
            end
         end
      end
   endgenerate

   assign out_ctl   = ctl_ff[NST-1];
   assign out_coord = coord_ff[NST-1];

endmodule

FILE: rtl/core/tcag_address.sv
`timescale 1ns / 1ps

module tcag_address
   import tcag_pkg::*;
#(
   parameter int MAX_DIMS    = DEF_MAX_DIMS,
   parameter int MAX_SOURCES = DEF_MAX_SOURCES,
   parameter int ADDR_BITS   = DEF_ADDR_BITS,
   localparam int CNT_D      = $clog2(MAX_DIMS + 1),
   localparam int CNT_S      = $clog2(MAX_SOURCES + 1),
   localparam int RUN_W      = WORD_W + $clog2(MAX_SOURCES + 1),
   localparam int SRC_W      = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             enable,
   input  logic [CNT_D-1:0]                                 dims_eff,
   input  logic [CNT_S-1:0]                                 srcs_eff,
   input  logic [1:0]                                       join_axis,
   input  logic [MAX_SOURCES-1:0][MAX_DIMS-1:0][WORD_W-1:0] stride,
   input  logic [MAX_SOURCES-1:0][WORD_W-1:0]               view_offset,
   input  logic [MAX_SOURCES-1:0][WORD_W-1:0]               buf_offset,
   input  logic [MAX_SOURCES-1:0][RUN_W-1:0]                range_lo,
   input  logic [MAX_SOURCES-1:0][RUN_W-1:0]                range_hi,
   input  ctl_type                                          in_ctl,
   input  logic [MAX_DIMS-1:0][WORD_W-1:0]                  in_coord,
   output logic                                             out_valid,
   output logic [WORD_W-1:0]                                out_address,
   output logic [NUM_W-1:0]                                 out_number,
   output logic                                             out_oor
);

   ctl_type                         b_ctl_ff, c_ctl_ff, d_ctl_ff;
   logic [MAX_DIMS-1:0][WORD_W-1:0] b_coord_ff, b_coord_in;
   logic [SRC_W-1:0]                b_src_ff, b_src_in, c_src_ff;
   logic                            b_found;
   logic [MAX_DIMS-1:0][ADDR_BITS-1:0] c_prod_ff, c_prod_in;
   logic [ADDR_BITS-1:0]            c_off_ff, c_off_in;
   logic [WORD_W-1:0]               d_addr_ff, d_addr_in;
   logic [NUM_W-1:0]                d_num_ff;

   // Pick the first source whose range covers the axis coordinate and rebase it.
   always_comb begin
      logic [WORD_W-1:0] axis;
      logic [RUN_W-1:0]  run;
      axis = '0;
      for (int d = 0; d < MAX_DIMS; d++)
         if (d == int'(join_axis) && d < int'(dims_eff)) axis = in_coord[d];
      b_found  = 1'b0;
      b_src_in = '0;
      run      = '0;
      for (int s = MAX_SOURCES - 1; s >= 0; s--) begin
         if (s < int'(srcs_eff) && RUN_W'(axis) < range_hi[s]) begin
            b_found  = 1'b1;
            b_src_in = SRC_W'(s);
            run      = range_lo[s];
         end
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (d >= int'(dims_eff))
            b_coord_in[d] = '0;
         else if (d == int'(join_axis))
            b_coord_in[d] = axis - run[WORD_W-1:0];
         else
            b_coord_in[d] = in_coord[d];
      end
   end

   // One multiplier per dimension against the chosen source's strides.
   always_comb begin
      logic [MAX_DIMS-1:0][WORD_W-1:0] row;
      logic [WORD_W-1:0]               view;
      logic [WORD_W-1:0]               bufo;
      logic [2*WORD_W-1:0]             prod;
      row  = '0;
      view = '0;
      bufo = '0;
      for (int s = 0; s < MAX_SOURCES; s++) begin
         if (int'(b_src_ff) == s) begin
            row  = stride[s];
            view = view_offset[s];
            bufo = buf_offset[s];
         end
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
         prod         = {{WORD_W{1'b0}}, b_coord_ff[d]} * {{WORD_W{1'b0}}, row[d]};
         c_prod_in[d] = prod[ADDR_BITS-1:0];
      end
      c_off_in = ADDR_BITS'(bufo) + ADDR_BITS'(view);
   end

   // Final address sum, wrapping at the address width.
   always_comb begin
      logic [ADDR_BITS-1:0] acc;
      logic [63:0]          wide;
      acc = c_off_ff;
      for (int d = 0; d < MAX_DIMS; d++) acc = acc + c_prod_ff[d];
      wide      = 64'(acc);
      d_addr_in = c_ctl_ff.oor ? '0 : wide[WORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff.valid <= 1'b0;
         c_ctl_ff.valid <= 1'b0;
         d_ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         b_ctl_ff.valid <= in_ctl.valid;
         c_ctl_ff.valid <= b_ctl_ff.valid;
         d_ctl_ff.valid <= c_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         b_ctl_ff.oor <= in_ctl.oor || !b_found;
         b_coord_ff   <= b_coord_in;
         b_src_ff     <= b_src_in;
         c_ctl_ff.oor <= b_ctl_ff.oor;
         c_src_ff     <= b_src_ff;
         c_prod_ff    <= c_prod_in;
         c_off_ff     <= c_off_in;
         d_ctl_ff.oor <= c_ctl_ff.oor;
         d_addr_ff    <= d_addr_in;
         d_num_ff     <= c_ctl_ff.oor ? '0 : NUM_W'(c_src_ff);
      end
   end

   assign out_valid   = d_ctl_ff.valid;
   assign out_address = d_addr_ff;
   assign out_number  = d_num_ff;
   assign out_oor     = d_ctl_ff.oor;

endmodule

FILE: rtl/core/tensor_concat_address_generator.sv
`timescale 1ns / 1ps

// Gather address generator for joining strided tensors along one axis.
// The request channel carries either an element request (op 0, a flat output
// index) or a descriptor table write (op 1). Each element request gives one
// response: the source number, the address in that source's buffer, and an
// out-of-range flag with address zero when the index or axis coordinate is
// not covered. Table writes give no response.
// Element requests enter one per cycle unless stalled, and pass the input
// stage, the divider (four quotient bits per stage for each dimension) and
// the address stages. A table write is taken only once every element request
// in flight has been answered. The user must see registers written through
// the csr channel only while the block is idle; the block does not enforce
// this. The csr channel is always ready. Synchronous reset empties the
// pipeline and restores register defaults; the descriptor tables hold nothing
// defined until written. When the receiver stalls, the whole pipeline holds
// and the request channel drops ready; nothing is lost or repeated.
module tensor_concat_address_generator
   import tcag_pkg::*;
#(
   parameter int MAX_DIMS    = DEF_MAX_DIMS,
   parameter int MAX_SOURCES = DEF_MAX_SOURCES,
   parameter int ADDR_BITS   = DEF_ADDR_BITS
) (
   input  logic  clock,
   input  logic  reset,
   tcag_req_if.sink   req_chan,
   tcag_rsp_if.source rsp_chan,
   tcag_csr_if.sink   csr_chan
);

   localparam int CNT_D    = $clog2(MAX_DIMS + 1);
   localparam int CNT_S    = $clog2(MAX_SOURCES + 1);
   localparam int RUN_W    = WORD_W + $clog2(MAX_SOURCES + 1);
   localparam int FLIGHT_W = $clog2(MAX_DIMS * DIV_STEPS + 8);

   logic [2:0]        dims_ff;
   logic [1:0]        join_ff;
   logic [2:0]        srcs_ff;
   logic [WORD_W-1:0] count_ff;
   logic [CNT_D-1:0]  dims_eff;
   logic [CNT_S-1:0]  srcs_eff;

   logic              enable;
   logic              req_fire, elem_fire, table_fire, rsp_fire;
   logic [FLIGHT_W-1:0] flight_ff;
   ctl_type           in_ctl_ff;
   logic [WORD_W-1:0] in_index_ff;

   logic [MAX_DIMS-1:0][WORD_W-1:0]                 shape;
   logic [MAX_SOURCES-1:0][MAX_DIMS-1:0][WORD_W-1:0] stride;
   logic [MAX_SOURCES-1:0][WORD_W-1:0]              view_offset;
   logic [MAX_SOURCES-1:0][WORD_W-1:0]              buf_offset;
   logic [MAX_SOURCES-1:0][RUN_W-1:0]               range_lo;
   logic [MAX_SOURCES-1:0][RUN_W-1:0]               range_hi;
   ctl_type                                         div_ctl;
   logic [MAX_DIMS-1:0][WORD_W-1:0]                 div_coord;

   // Configuration registers.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff  <= 3'd1;
         join_ff  <= 2'd0;
         srcs_ff  <= 3'd1;
         count_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_DIMS:    dims_ff  <= csr_chan.data[2:0];
            CSR_JOIN:    join_ff  <= csr_chan.data[1:0];
            CSR_SOURCES: srcs_ff  <= csr_chan.data[2:0];
            CSR_COUNT:   count_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Counts above the built-in maxima saturate.
   assign dims_eff = (int'(dims_ff) > MAX_DIMS) ? CNT_D'(MAX_DIMS) : CNT_D'(dims_ff);
   assign srcs_eff = (int'(srcs_ff) > MAX_SOURCES) ? CNT_S'(MAX_SOURCES) : CNT_S'(srcs_ff);

   // One stall for the whole pipeline; table writes wait for an empty pipeline.
   assign enable         = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = enable && (req_chan.op == OP_ELEMENT || flight_ff == '0);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign elem_fire      = req_fire && req_chan.op == OP_ELEMENT;
   assign table_fire     = req_fire && req_chan.op == OP_TABLE;
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         flight_ff <= '0;
      end else begin
         priority if (elem_fire && !rsp_fire) begin
            flight_ff <= flight_ff + FLIGHT_W'(1);
         end else if (rsp_fire && !elem_fire) begin
            flight_ff <= flight_ff - FLIGHT_W'(1);
         end else begin
            flight_ff <= flight_ff;
         end
      end
   end

   // Input stage: capture the index and check it against the element count.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         in_ctl_ff.valid <= elem_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         in_ctl_ff.oor <= req_chan.element_index >= count_ff;
         in_index_ff   <= req_chan.element_index;
      end
   end

   tcag_tables #(
      .MAX_DIMS    (MAX_DIMS),
      .MAX_SOURCES (MAX_SOURCES)
   ) u_tables (
      .clock       (clock),
      .wr_en       (table_fire),
      .wr_sel      (req_chan.table_select),
      .wr_slot     (req_chan.table_slot),
      .wr_word     (req_chan.table_word),
      .shape       (shape),
      .stride      (stride),
      .view_offset (view_offset),
      .buf_offset  (buf_offset),
      .range_lo    (range_lo),
      .range_hi    (range_hi)
   );

   tcag_divider #(
      .MAX_DIMS (MAX_DIMS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .shape     (shape),
      .dims_eff  (dims_eff),
      .in_ctl    (in_ctl_ff),
      .in_index  (in_index_ff),
      .out_ctl   (div_ctl),
      .out_coord (div_coord)
   );

   tcag_address #(
      .MAX_DIMS    (MAX_DIMS),
      .MAX_SOURCES (MAX_SOURCES),
      .ADDR_BITS   (ADDR_BITS)
   ) u_address (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .dims_eff    (dims_eff),
      .srcs_eff    (srcs_eff),
      .join_axis   (join_ff),
      .stride      (stride),
      .view_offset (view_offset),
      .buf_offset  (buf_offset),
      .range_lo    (range_lo),
      .range_hi    (range_hi),
      .in_ctl      (div_ctl),
      .in_coord    (div_coord),
      .out_valid   (rsp_chan.valid),
      .out_address (rsp_chan.source_address),
      .out_number  (rsp_chan.source_number),
      .out_oor     (rsp_chan.out_of_range)
   );

endmodule
